[hdl/ghb_pkg.sv]
// Shared types and constants for the GHB delta prefetcher.
package ghb_pkg;
	localparam int HIST_DEPTH_DEF = 32;
	localparam int INDEX_DEPTH_DEF = 32;
	localparam int ADDR_BITS_DEF = 32;
	localparam int OUT_BITS = 32;
	localparam int CFG_BITS = 32;
	localparam int CFG_IDX_BITS = 3;
	localparam logic [3:0] MAX_OUT = 4'd8;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_BYTES = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ADDRESS = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SEQ_DEGREE = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_CHAIN_WIDTH = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_REPLAY_DEPTH = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch incoming address
		logic lookup;    // read old head address
		logic update;    // compute delta, sign and index slot
		logic commit;    // probe index table, write history and index table
		logic seq_init;
		logic seq_step;  // add one block, emit
		logic walk_init; // load base of current link
		logic cand_rd;   // read candidate entry
		logic replay;    // apply candidate delta to the running address
		logic emit_cur;  // load the running address into the output register
		logic out_take;  // output register drained
	} ghb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic link_on;
		logic seq_more;
		logic walk_more;  // another link may be followed
		logic cand_more;  // another candidate in this link
		logic replay_hit; // replay gives a result
	} ghb_stat_t;
endpackage

[hdl/ghb_datapath.sv]
// Datapath: history buffer, index table, address arithmetic.
module ghb_datapath import ghb_pkg::*; #(
	parameter int HIST_DEPTH = HIST_DEPTH_DEF,
	parameter int INDEX_DEPTH = INDEX_DEPTH_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [31:0]          access_addr,
	input  logic [12:0]          block_bytes,
	input  logic [31:0]          max_address,
	input  logic [3:0]           seq_degree,
	input  logic [3:0]           chain_width,
	input  logic [3:0]           replay_depth,
	input  ghb_cmd_t             cmd,
	output ghb_stat_t            stat,
	output logic [OUT_BITS-1:0]  result_addr
);
	localparam int HB = $clog2(HIST_DEPTH);
	localparam int IB = $clog2(INDEX_DEPTH);
	localparam int AW = ADDR_BITS;

	// history and index storage
	logic [AW-1:0] hist_addr_mem [HIST_DEPTH];
	logic [HB-1:0] hist_link_mem [HIST_DEPTH];
	logic [HIST_DEPTH-1:0] hist_valid_q, hist_lon_q;
	logic [AW-1:0] idx_delta_mem [INDEX_DEPTH];
	logic          idx_sign_mem  [INDEX_DEPTH];
	logic [HB-1:0] idx_entry_mem [INDEX_DEPTH];
	logic [INDEX_DEPTH-1:0] idx_valid_q;
	logic [HB-1:0] head_q;
	logic          head_present_q;

	logic [AW-1:0] addr_q, old_q, delta_q, base_q, cur_q, ca_q;
	logic          sign_q, link_on_q, p_on_q;
	logic [HB-1:0] new_head_q, p_q, cand_q;
	logic [IB-1:0] slot_q;
	logic [3:0]    count_q, width_q, depth_q;
	logic [OUT_BITS-1:0] res_q;

	logic [AW-1:0] sum_seq, dl, new_cur;
	logic          dl_down, rep_ok;
	logic [3:0]    seq_lim, dep_lim;
	logic [HB-1:0] head_next, cand_next;
	logic [AW:0]   mx, cur_plus;

	assign seq_lim = (seq_degree > MAX_OUT) ? MAX_OUT : seq_degree;
	assign dep_lim = (replay_depth > MAX_OUT) ? MAX_OUT : replay_depth;
	assign head_next = (head_q == HB'(HIST_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign cand_next = (cand_q == HB'(HIST_DEPTH - 1)) ? '0 : cand_q + 1'b1;
	assign sum_seq = cur_q + AW'(block_bytes);

	// replay arithmetic on the registered candidate
	always_comb begin
		dl_down = base_q > ca_q;
		dl = dl_down ? base_q - ca_q : ca_q - base_q;
		mx = (AW+1)'(max_address);
		cur_plus = {1'b0, cur_q} + {1'b0, dl};
		if (dl_down) begin
			rep_ok = cur_q > dl;
			new_cur = cur_q - dl;
		end else begin
			rep_ok = ({1'b0, dl} < mx) && (cur_plus < mx);
			new_cur = cur_plus[AW-1:0];
		end
	end

	assign stat.link_on = link_on_q;
	assign stat.seq_more = count_q < seq_lim;
	assign stat.walk_more = p_on_q && (width_q < chain_width);
	assign stat.cand_more = (cand_q != head_q) && (depth_q < dep_lim);
	assign stat.replay_hit = rep_ok;
	assign result_addr = res_q;

	// control-like state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_valid_q <= '0;
			hist_lon_q <= '0;
			idx_valid_q <= '0;
			head_q <= '0;
			head_present_q <= 1'b0;
		end else if (cmd.commit) begin
			head_q <= new_head_q;
			head_present_q <= 1'b1;
			hist_valid_q[new_head_q] <= 1'b1;
			if (head_present_q) idx_valid_q[slot_q] <= 1'b1;
		end else if (cmd.seq_init) begin
			// record the link flag of the new head once it is known
			hist_lon_q[head_q] <= link_on_q;
		end
	end

	// storage writes and working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q <= AW'(access_addr);
			new_head_q <= head_present_q ? head_next : '0;
		end
		if (cmd.lookup) old_q <= hist_addr_mem[head_q];
		if (cmd.update) begin
			sign_q <= !(old_q > addr_q);
			delta_q <= (old_q > addr_q) ? old_q - addr_q : addr_q - old_q;
			slot_q <= (old_q > addr_q) ? IB'((old_q - addr_q) % INDEX_DEPTH)
				: IB'((addr_q - old_q) % INDEX_DEPTH);
		end
		if (cmd.commit) begin
			// a link to the entry being replaced counts as none
			link_on_q <= head_present_q && idx_valid_q[slot_q]
				&& hist_valid_q[idx_entry_mem[slot_q]]
				&& (idx_entry_mem[slot_q] != new_head_q)
				&& idx_delta_mem[slot_q] == delta_q && idx_sign_mem[slot_q] == sign_q;
			p_q <= idx_entry_mem[slot_q];
			hist_addr_mem[new_head_q] <= addr_q;
			if (head_present_q) begin
				idx_delta_mem[slot_q] <= delta_q;
				idx_sign_mem[slot_q] <= sign_q;
				idx_entry_mem[slot_q] <= new_head_q;
			end
		end
		if (cmd.commit) begin
			hist_link_mem[new_head_q] <= (head_present_q && idx_valid_q[slot_q]
				&& hist_valid_q[idx_entry_mem[slot_q]]
				&& (idx_entry_mem[slot_q] != new_head_q)
				&& idx_delta_mem[slot_q] == delta_q && idx_sign_mem[slot_q] == sign_q)
				? idx_entry_mem[slot_q] : '0;
		end
		if (cmd.seq_init) begin
			cur_q <= addr_q;
			count_q <= '0;
			width_q <= '0;
			depth_q <= '0;
			p_on_q <= 1'b1;
		end
		if (cmd.seq_step) begin
			cur_q <= sum_seq;
			res_q <= OUT_BITS'(sum_seq);
			count_q <= count_q + 1'b1;
		end
		if (cmd.walk_init) begin
			base_q <= hist_addr_mem[p_q];
			cand_q <= (p_q == HB'(HIST_DEPTH - 1)) ? '0 : p_q + 1'b1;
			width_q <= width_q + 1'b1;
		end
		if (cmd.cand_rd) begin
			ca_q <= hist_addr_mem[cand_q];
			cand_q <= cand_next;
			depth_q <= depth_q + 1'b1;
			if (p_on_q) begin
				p_on_q <= hist_lon_q[p_q];
				p_q <= hist_link_mem[p_q];
			end
		end
		if (cmd.replay && rep_ok) cur_q <= new_cur;
		// hand the held replay address to the output register
		if (cmd.emit_cur) res_q <= OUT_BITS'(cur_q);
	end

	// the depth count stays within MAX_OUT after each candidate read
	property p_depth_cap;
		@(posedge clk) disable iff (!arst_n) cmd.cand_rd |=> depth_q <= MAX_OUT;
	endproperty
	a_depth_cap: assert property (p_depth_cap) else $error("replay depth overrun");

	property p_head_after_commit;
		@(posedge clk) disable iff (!arst_n) cmd.commit |=> head_present_q;
	endproperty
	a_head_after_commit: assert property (p_head_after_commit)
		else $error("head not present after commit");

	property p_valid_head;
		@(posedge clk) disable iff (!arst_n) $past(cmd.commit) |-> hist_valid_q[head_q];
	endproperty
	a_valid_head: assert property (p_valid_head) else $error("head entry not valid");
endmodule

[hdl/ghb_ctrl.sv]
// Controller state machine sequencing one miss through the datapath.
module ghb_ctrl import ghb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      is_miss,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output logic      out_last,
	input  ghb_stat_t stat,
	output ghb_cmd_t  cmd
);
	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_LOOKUP = 10'b0000000010,
		S_UPDATE = 10'b0000000100,
		S_COMMIT = 10'b0000001000,
		S_BRANCH = 10'b0000010000,
		S_SEQ    = 10'b0000100000,
		S_WALK   = 10'b0001000000,
		S_CAND   = 10'b0010000000,
		S_REPLAY = 10'b0100000000,
		S_EMIT   = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   valid_q, valid_d, last_q, last_d, pend_q, pend_d, in_take, out_free;

	assign in_ready = (state_q == S_IDLE);
	assign in_take = in_valid && in_ready;
	assign out_valid = valid_q;
	assign out_last = last_q;
	assign out_free = !valid_q || out_ready;

	// next state and commands
	always_comb begin
		cmd = '0;
		state_d = state_q;
		valid_d = valid_q;
		last_d = last_q;
		pend_d = pend_q;
		if (valid_q && out_ready) valid_d = 1'b0;
		cmd.out_take = valid_q && out_ready;
		case (state_q)
			S_IDLE: begin
				if (in_take && is_miss) begin
					cmd.capture = 1'b1;
					state_d = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = S_BRANCH;
			end
			S_BRANCH: begin
				cmd.seq_init = 1'b1;
				state_d = stat.link_on ? S_WALK : S_SEQ;
			end
			S_SEQ: begin
				// hold while the previous result waits
				if (!stat.seq_more) state_d = S_IDLE;
				else if (out_free) begin
					cmd.seq_step = 1'b1;
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				// sequential result just loaded; decide whether it is final
				valid_d = 1'b1;
				last_d = !stat.seq_more;
				state_d = S_SEQ;
			end
			S_WALK: begin
				if (stat.walk_more) begin
					cmd.walk_init = 1'b1;
					state_d = S_CAND;
				end else if (!pend_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					// release the held address as the final result
					cmd.emit_cur = 1'b1;
					valid_d = 1'b1;
					last_d = 1'b1;
					pend_d = 1'b0;
					state_d = S_IDLE;
				end
			end
			S_CAND: begin
				if (!stat.cand_more) state_d = S_WALK;
				else begin
					cmd.cand_rd = 1'b1;
					state_d = S_REPLAY;
				end
			end
			S_REPLAY: begin
				// hold each replayed address until the next one is known
				if (!stat.replay_hit) state_d = S_CAND;
				else if (!pend_q) begin
					cmd.replay = 1'b1;
					pend_d = 1'b1;
					state_d = S_CAND;
				end else if (out_free) begin
					cmd.emit_cur = 1'b1;
					cmd.replay = 1'b1;
					valid_d = 1'b1;
					last_d = 1'b0;
					state_d = S_CAND;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
			last_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= valid_d;
			last_q <= last_d;
			pend_q <= pend_d;
		end
	end

	property p_onehot;
		@(posedge clk) disable iff (!arst_n) $onehot(state_q);
	endproperty
	a_onehot: assert property (p_onehot) else $error("state not one-hot");

	property p_no_overwrite;
		@(posedge clk) disable iff (!arst_n)
			(cmd.seq_step || cmd.emit_cur) |-> (!valid_q || out_ready);
	endproperty
	a_no_overwrite: assert property (p_no_overwrite) else $error("result overwritten");

	property p_emit_valid;
		@(posedge clk) disable iff (!arst_n) state_q == S_EMIT |=> out_valid;
	endproperty
	a_emit_valid: assert property (p_emit_valid) else $error("emit without valid");

	property p_idle_no_pend;
		@(posedge clk) disable iff (!arst_n) state_q == S_IDLE |-> !pend_q;
	endproperty
	a_idle_no_pend: assert property (p_idle_no_pend) else $error("held result left behind");
endmodule

[hdl/ghb_delta_prefetcher_unit.sv]
// Top level of the GHB delta-correlation prefetcher.
//  channel  direction  handshake             payload
//  in       input      in_valid/in_ready     access_addr, is_miss
//  out      output     out_valid/out_ready   prefetch_addr, last
//  cfg      input      cfg_we                cfg_index, cfg_data
// A hit is only accepted. A miss is captured on its transfer, then passes history
// lookup, delta update, commit and a branch step, then the sequential prefetches,
// or per chain link a base load, a read and replay per candidate and a link close,
// and a last step that releases the held final replay result.
// Results leave through one output register; a stall holds the walk. Each replayed
// address is held back until the next is found, so last marks the true final one.
// arst_n clears control state, valid bits and configuration registers to reset values.
module ghb_delta_prefetcher_unit import ghb_pkg::*; #(
	parameter int HIST_DEPTH = HIST_DEPTH_DEF,
	parameter int INDEX_DEPTH = INDEX_DEPTH_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [31:0]             access_addr,
	input  logic                    is_miss,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [31:0]             prefetch_addr,
	output logic                    last,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data
);
	logic [12:0] block_bytes_q;
	logic [31:0] max_address_q;
	logic [3:0]  seq_degree_q, chain_width_q, replay_depth_q;
	ghb_cmd_t    cmd;
	ghb_stat_t   stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q <= 13'd64;
			max_address_q <= 32'd268435456;
			seq_degree_q <= 4'd3;
			chain_width_q <= 4'd3;
			replay_depth_q <= 4'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLOCK_BYTES: block_bytes_q <= cfg_data[12:0];
				REG_MAX_ADDRESS: max_address_q <= cfg_data[31:0];
				REG_SEQ_DEGREE: seq_degree_q <= cfg_data[3:0];
				REG_CHAIN_WIDTH: chain_width_q <= cfg_data[3:0];
				REG_REPLAY_DEPTH: replay_depth_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	ghb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .is_miss(is_miss),
		.in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
		.out_last(last), .stat(stat), .cmd(cmd)
	);

	ghb_datapath #(
		.HIST_DEPTH(HIST_DEPTH), .INDEX_DEPTH(INDEX_DEPTH), .ADDR_BITS(ADDR_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .access_addr(access_addr),
		.block_bytes(block_bytes_q), .max_address(max_address_q),
		.seq_degree(seq_degree_q), .chain_width(chain_width_q),
		.replay_depth(replay_depth_q), .cmd(cmd), .stat(stat),
		.result_addr(prefetch_addr)
	);
endmodule

[tb/ghb_delta_prefetcher_unit_test.sv]
// Self-checking testbench for the GHB delta-correlation prefetcher.
`timescale 1ns / 100ps

module ghb_delta_prefetcher_unit_test;
	import ghb_pkg::*;

	localparam int HDEPTH = 32;
	localparam int IDEPTH = 32;
	localparam int SETTLE = 100;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		logic [31:0] addr;
		logic        last;
	} prefetch_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [31:0]             access_addr;
	logic                    is_miss;
	logic                    out_valid;
	logic                    out_ready;
	logic [31:0]             prefetch_addr;
	logic                    last;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0]     cfg_data;

	// register shadows
	logic [12:0] blk_bytes;
	logic [31:0] max_addr;
	logic [3:0]  seq_deg;
	logic [3:0]  chain_w;
	logic [3:0]  rep_depth;

	// shadow of the history buffer and index table
	logic [31:0] h_addr [HDEPTH];
	logic        h_valid [HDEPTH];
	logic [4:0]  h_link [HDEPTH];
	logic        h_link_on [HDEPTH];
	logic [4:0]  head;
	logic        head_on;
	logic [31:0] ix_delta [IDEPTH];
	logic        ix_sign [IDEPTH];
	logic        ix_valid [IDEPTH];
	logic [4:0]  ix_entry [IDEPTH];

	prefetch_t pending_prefetches[$];
	int errors;
	int accesses;
	int misses;
	int prefetches;
	int idle_cycles;
	bit quiet_in;
	bit quiet_out;

	ghb_delta_prefetcher_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.access_addr(access_addr), .is_miss(is_miss),
		.out_valid(out_valid), .out_ready(out_ready),
		.prefetch_addr(prefetch_addr), .last(last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report(input string what);
		$display("ERROR t=%0t: %s", $time, what);
		errors++;
	endtask

	// Work out the prefetches one accepted miss causes.
	task automatic predict_prefetches(input logic [31:0] a);
		logic [4:0] nh, lnk, p, cand, np;
		logic lnk_on, sgn, p_on;
		longint unsigned old, d, base, ca, cur, blk;
		int slot, n, wdt, dpt, dlim, lim;
		prefetch_t e;
		n = 0;
		lnk = 0;
		lnk_on = 1'b0;
		nh = head_on ? head + 5'd1 : 5'd0;
		h_valid[nh] = 1'b0;
		if (head_on) begin
			old = h_addr[head];
			if (old > a) begin
				d = old - a;
				sgn = 1'b0;
			end else begin
				d = a - old;
				sgn = 1'b1;
			end
			slot = int'(d % IDEPTH);
			if (ix_valid[slot] && h_valid[ix_entry[slot]] && ix_delta[slot] == d
					&& ix_sign[slot] == sgn) begin
				lnk_on = 1'b1;
				lnk = ix_entry[slot];
			end
			ix_delta[slot] = d[31:0];
			ix_sign[slot] = sgn;
			ix_entry[slot] = nh;
			ix_valid[slot] = 1'b1;
		end
		head = nh;
		head_on = 1'b1;
		h_addr[nh] = a;
		h_link[nh] = lnk;
		h_link_on[nh] = lnk_on;
		h_valid[nh] = 1'b1;

		if (!lnk_on) begin
			// sequential lookahead
			lim = seq_deg > 8 ? 8 : seq_deg;
			cur = a;
			blk = blk_bytes;
			for (int k = 0; k < lim; k++) begin
				cur = (cur + blk) & 64'hFFFF_FFFF;
				e.addr = cur[31:0];
				e.last = 1'b0;
				pending_prefetches.push_back(e);
				n++;
			end
		end else begin
			// walk the chain and replay later deltas
			wdt = 0;
			dpt = 0;
			dlim = rep_depth > 8 ? 8 : rep_depth;
			p = lnk;
			p_on = 1'b1;
			cur = a;
			while (p_on && wdt < chain_w) begin
				base = h_addr[p];
				cand = p + 5'd1;
				wdt++;
				while (cand != head && dpt < dlim) begin
					ca = h_addr[cand];
					dpt++;
					cand = cand + 5'd1;
					if (p_on) begin
						np = h_link[p];
						p_on = h_link_on[p];
						p = np;
					end
					if (base > ca) begin
						d = base - ca;
						if (cur > d) cur = cur - d;
						else continue;
					end else begin
						d = ca - base;
						if (d < max_addr && cur < max_addr - d) cur = cur + d;
						else continue;
					end
					e.addr = cur[31:0];
					e.last = 1'b0;
					pending_prefetches.push_back(e);
					n++;
				end
			end
		end
		if (n > 0) pending_prefetches[$].last = 1'b1;
	endtask

	// Predict on each input transfer, check each output transfer.
	always @(posedge clk) begin
		prefetch_t e;
		if (arst_n && in_valid && in_ready) begin
			accesses++;
			if (is_miss) begin
				misses++;
				predict_prefetches(access_addr);
			end
		end
		if (arst_n && out_valid && out_ready) begin
			prefetches++;
			if (pending_prefetches.size() == 0) begin
				report($sformatf("unexpected prefetch %h", prefetch_addr));
			end else begin
				e = pending_prefetches.pop_front();
				if (prefetch_addr !== e.addr)
					report($sformatf("prefetch_addr %h, want %h", prefetch_addr, e.addr));
				if (last !== e.last)
					report($sformatf("last %b, want %b at %h", last, e.last, e.addr));
			end
		end
	end

	// Stall the result side at random.
	always @(posedge clk) begin
		out_ready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 28);
	end

	// End the run when no transfer happens for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_access(input logic [31:0] a, input logic m);
		if (!quiet_in) begin
			while ($urandom_range(99) < 28) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		access_addr <= a;
		is_miss <= m;
		// ready is settled mid-cycle; the next rising edge takes the transfer
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	// Hold input, wait for every expected prefetch, then let the block settle.
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_prefetches.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BLOCK_BYTES: blk_bytes = v[12:0];
			REG_MAX_ADDRESS: max_addr = v;
			REG_SEQ_DEGREE: seq_deg = v[3:0];
			REG_CHAIN_WIDTH: chain_w = v[3:0];
			REG_REPLAY_DEPTH: rep_depth = v[3:0];
			default: ;
		endcase
	endtask

	task automatic set_all(input logic [31:0] bb, input logic [31:0] ma,
			input logic [31:0] sd, input logic [31:0] cw, input logic [31:0] rd);
		write_reg(REG_BLOCK_BYTES, bb);
		write_reg(REG_MAX_ADDRESS, ma);
		write_reg(REG_SEQ_DEGREE, sd);
		write_reg(REG_CHAIN_WIDTH, cw);
		write_reg(REG_REPLAY_DEPTH, rd);
	endtask

	// Send a repeating delta pattern so that history chains form.
	task automatic run_pattern(input int reps, input logic [31:0] span);
		logic [31:0] a, dl [4];
		int len;
		a = $urandom();
		len = $urandom_range(4, 1);
		for (int i = 0; i < len; i++) begin
			dl[i] = $urandom_range(span);
			if ($urandom_range(1)) dl[i] = -dl[i];
		end
		for (int r = 0; r < reps; r++) begin
			for (int i = 0; i < len; i++) begin
				a = a + dl[i];
				if ($urandom_range(9) == 0) send_access($urandom(), 1'($urandom_range(1)));
				send_access(a, 1'b1);
			end
		end
	endtask

	task automatic test_directed;
		send_access(32'h0000_1000, 1'b0);
		send_access(32'h0000_0000, 1'b1);
		send_access(32'hFFFF_FFFF, 1'b1);
		send_access(32'hFFFF_FFC0, 1'b1);
		send_access(32'hFFFF_FFC0, 1'b1);
		send_access(32'hFFFF_FFC0, 1'b1);
		send_access(32'hFFFF_FFC0, 1'b1);
		send_access(32'h0000_0040, 1'b1);
		for (int i = 0; i < 8; i++) send_access(32'h0010_0000 + i * 32'h100, 1'b1);
		for (int i = 0; i < 6; i++) send_access(32'h0800_0000 - i * 32'h40, 1'b1);
		send_access(32'hFFFF_FFFF, 1'b0);
		drain();
	endtask

	task automatic test_register_extremes;
		set_all(1, 1, 1, 1, 1);
		run_pattern(4, 32'h100);
		drain();
		set_all(4096, 32'hFFFF_FFFF, 8, 8, 8);
		run_pattern(5, 32'h1000);
		drain();
		set_all(4096, 32'hFFFF_FFFF, 15, 15, 15);
		run_pattern(5, 32'h40);
		drain();
		set_all(64, 32'h1000_0000, 0, 0, 8);
		run_pattern(4, 32'h100);
		drain();
	endtask

	task automatic test_random;
		for (int ph = 0; ph < 5; ph++) begin
			set_all($urandom_range(4096, 1), ph == 0 ? 32'hFFFF_FFFF : $urandom(),
				$urandom_range(8, 1), $urandom_range(8, 1), $urandom_range(8, 1));
			quiet_in = (ph == 2);
			quiet_out = (ph == 2);
			for (int k = 0; k < 4; k++) run_pattern($urandom_range(4, 2), 32'h800);
			for (int k = 0; k < 6; k++) send_access($urandom(), 1'($urandom_range(1)));
			if (ph == 3) begin
				// wait out every prefetch before carrying on
				drain();
			end
			run_pattern(3, 32'hFFFF_FFFF);
			drain();
		end
		quiet_in = 0;
		quiet_out = 0;
	endtask

	initial begin
		errors = 0;
		accesses = 0;
		misses = 0;
		prefetches = 0;
		idle_cycles = 0;
		quiet_in = 0;
		quiet_out = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		access_addr <= '0;
		is_miss <= 1'b0;
		out_ready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		blk_bytes = 13'd64;
		max_addr = 32'h1000_0000;
		seq_deg = 4'd3;
		chain_w = 4'd3;
		rep_depth = 4'd2;
		head = '0;
		head_on = 1'b0;
		for (int i = 0; i < HDEPTH; i++) begin
			h_valid[i] = 1'b0;
			h_link_on[i] = 1'b0;
			h_link[i] = '0;
			h_addr[i] = '0;
		end
		for (int i = 0; i < IDEPTH; i++) begin
			ix_valid[i] = 1'b0;
			ix_delta[i] = '0;
			ix_sign[i] = 1'b0;
			ix_entry[i] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_register_extremes();
		test_random();
		drain();

		$display("covered %0d accesses (%0d misses) and %0d prefetches", accesses, misses,
			prefetches);
		$display("register extremes, chain walks, sequential wrap and stalls exercised");
		if (errors == 0 && pending_prefetches.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d errors, %0d prefetches never seen", errors,
				pending_prefetches.size());
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
